// ----- rtl/core/smas_pkg.sv -----
// Shared types and constants of the SPI memory access slave.
`timescale 1ns / 1ps

package smas_pkg;

    localparam int ADDR_W = 22;

    typedef logic [ADDR_W-1:0] t_addr;
    typedef logic [2:0]        t_phase;
    typedef logic [1:0]        t_cfg_idx;
    typedef logic [1:0]        t_host_op;

    // Phase codes as seen by the host.
    localparam t_phase PH_IDLE    = 3'd0;
    localparam t_phase PH_RD_ADDR = 3'd1;
    localparam t_phase PH_WR_ADDR = 3'd2;
    localparam t_phase PH_RD_DATA = 3'd3;
    localparam t_phase PH_WR_DATA = 3'd4;
    localparam t_phase PH_UNIMPL  = 3'd5;
    localparam t_phase PH_INVALID = 3'd6;

    // Access kind in bits 7:6 of the first byte.
    localparam t_host_op HOST_READ    = 2'd0;
    localparam t_host_op HOST_UNIMPL  = 2'd1;
    localparam t_host_op HOST_WRITE   = 2'd2;
    localparam t_host_op HOST_INVALID = 2'd3;

    // Item kinds on the input channel.
    localparam logic CMD_TRANSFER = 1'b0;
    localparam logic CMD_SELECT   = 1'b1;

    // Configuration register indexes.
    localparam t_cfg_idx CFG_RING_BASE   = 2'd0;
    localparam t_cfg_idx CFG_WINDOW_ADDR = 2'd1;
    localparam t_cfg_idx CFG_WRAP_EN     = 2'd2;

    localparam t_addr RING_BASE_RST   = 22'h108000;
    localparam t_addr WINDOW_ADDR_RST = 22'h302578;
    localparam t_addr RING_LAST_OFS   = 22'd4095;
    localparam t_addr WINDOW_LAST_OFS = 22'd3;

    // Address bytes that follow the first byte of a transaction.
    localparam logic [1:0] ADDR_TAIL_BYTES = 2'd2;

    // Work handed from the control stage to the memory stage.
    typedef enum logic [2:0] {
        OP_NONE     = 3'd0,
        OP_RD_START = 3'd1,
        OP_RD_BYTE  = 3'd2,
        OP_WR_START = 3'd3,
        OP_WR_BYTE  = 3'd4,
        OP_FLUSH    = 3'd5
    } t_op;

    typedef struct packed {
        t_op        op;
        t_addr      cursor;
        logic [1:0] fill;
        logic [7:0] data;
        t_phase     phase;
    } t_dp_req;

    typedef struct packed {
        logic [7:0] reply;
        t_phase     phase;
    } t_result;

    typedef struct packed {
        logic busy;
        logic in_flight;
    } t_dp_stat;

endpackage

// ----- rtl/core/spi_memory_access_slave.sv -----
// Top level of the SPI memory access slave: command decode, cursor control and result queue.
`timescale 1ns / 1ps

// Channel  Dir  Handshake                   Payload
// in       in   i_in_valid / o_in_stall     i_cmd, i_data_byte, i_select_level
// out      out  o_out_valid / i_out_stall   o_reply_byte, o_phase
// cfg      in   i_cfg_we                    i_cfg_idx, i_cfg_data
//
// One input transfer per cycle while o_in_stall is low; a select change that closes a
// partly filled write word stalls the input while the memory stage reads a second word
// through the single RAM read port. Each input transfer is registered into the memory
// stage and its result into the result queue; such a flush first reads its second word.
// After reset a clearing pass writes zero to all MEM_WORDS words (MEM_WORDS a power of
// two) with o_in_stall high; configuration writes are taken throughout. A four-entry
// result queue absorbs output stalls; o_in_stall also rises while a flush reads its
// second word and when the queue and the memory stage could not hold one more item.

module spi_memory_access_slave import smas_pkg::*; #(
    parameter int MEM_WORDS = 4096
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_cmd,
    input  logic [7:0]  i_data_byte,
    input  logic        i_select_level,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [7:0]  o_reply_byte,
    output logic [2:0]  o_phase,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [21:0] i_cfg_data
);

    localparam int OUT_DEPTH = 4;
    localparam int PTR_W     = $clog2(OUT_DEPTH);
    localparam int CNT_W     = $clog2(OUT_DEPTH + 1);

    t_phase     r_phase,       n_phase;
    t_addr      r_cursor,      n_cursor;
    logic [1:0] r_addr_cnt,    n_addr_cnt;
    logic [1:0] r_fill,        n_fill;
    t_addr      r_write_start, n_write_start;
    logic       r_selected,    n_selected;

    t_addr      r_ring_base;
    t_addr      r_ring_end;
    t_addr      r_win_addr;
    t_addr      r_win_end;
    logic       r_wrap_en;

    t_result          r_fifo [OUT_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    t_dp_req    req;
    t_dp_stat   dp_stat;
    logic       res_valid;
    t_result    res;
    logic       in_ready;
    logic       in_accept;
    logic       pop;
    logic       wr_step;
    t_addr      ws;
    logic [1:0] fill_eff;

    assign in_ready   = !dp_stat.busy &&
                       ((r_count + CNT_W'(dp_stat.in_flight)) < CNT_W'(OUT_DEPTH));
    assign in_accept  = i_in_valid && in_ready;
    assign o_in_stall = !in_ready;

    always_comb begin
        n_phase       = r_phase;
        n_cursor      = r_cursor;
        n_addr_cnt    = r_addr_cnt;
        n_fill        = r_fill;
        n_write_start = r_write_start;
        n_selected    = r_selected;
        req.op        = OP_NONE;
        req.cursor    = r_cursor;
        req.fill      = r_fill;
        req.data      = i_data_byte;
        wr_step       = 1'b0;
        ws            = r_write_start;
        fill_eff      = r_fill;
        if (in_accept) begin
            if (i_cmd == CMD_SELECT) begin
                if (i_select_level != r_selected) begin
                    n_selected = i_select_level;
                    if (r_fill != 2'd0) begin
                        req.op = OP_FLUSH;
                    end
                    n_phase    = PH_IDLE;
                    n_cursor   = '0;
                    n_addr_cnt = 2'd0;
                    n_fill     = 2'd0;
                end
            end else if (r_selected) begin
                case (r_phase)
                    PH_IDLE: begin
                        case (i_data_byte[7:6])
                            HOST_READ: begin
                                n_phase  = PH_RD_ADDR;
                                n_cursor = t_addr'(i_data_byte[5:0]);
                            end
                            HOST_UNIMPL: begin
                                n_phase = PH_UNIMPL;
                            end
                            HOST_WRITE: begin
                                n_phase  = PH_WR_ADDR;
                                n_cursor = t_addr'(i_data_byte[5:0]);
                            end
                            default: begin
                                n_phase = PH_INVALID;
                            end
                        endcase
                    end
                    PH_RD_ADDR, PH_WR_ADDR: begin
                        if (r_addr_cnt < ADDR_TAIL_BYTES) begin
                            n_addr_cnt = r_addr_cnt + 2'd1;
                            n_cursor   = {r_cursor[13:0], i_data_byte};
                        end else if (r_phase == PH_RD_ADDR) begin
                            n_phase = PH_RD_DATA;
                            req.op  = OP_RD_START;
                        end else begin
                            // The byte after the address bytes is the first data byte.
                            n_phase       = PH_WR_DATA;
                            req.op        = OP_WR_START;
                            n_write_start = r_cursor;
                            ws            = r_cursor;
                            fill_eff      = r_cursor[1:0];
                            req.fill      = r_cursor[1:0];
                            wr_step       = 1'b1;
                        end
                    end
                    PH_RD_DATA: begin
                        req.op   = OP_RD_BYTE;
                        n_cursor = r_cursor + 22'd1;
                    end
                    PH_WR_DATA: begin
                        req.op  = OP_WR_BYTE;
                        wr_step = 1'b1;
                    end
                    default: begin
                    end
                endcase
            end
            if (wr_step) begin
                n_fill = fill_eff + 2'd1;
                if ((r_cursor == r_ring_end) && (ws >= r_ring_base)) begin
                    n_cursor = r_ring_base;
                end else if (r_wrap_en && (r_cursor == r_win_end)) begin
                    n_cursor = r_win_addr;
                end else begin
                    n_cursor = r_cursor + 22'd1;
                end
            end
        end
        req.phase = n_phase;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_IDLE;
            r_cursor      <= '0;
            r_addr_cnt    <= 2'd0;
            r_fill        <= 2'd0;
            r_write_start <= '0;
            r_selected    <= 1'b0;
        end else begin
            r_phase       <= n_phase;
            r_cursor      <= n_cursor;
            r_addr_cnt    <= n_addr_cnt;
            r_fill        <= n_fill;
            r_write_start <= n_write_start;
            r_selected    <= n_selected;
        end
    end

    // Wrap end addresses are kept next to their bases so the cursor compare is direct.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ring_base <= RING_BASE_RST;
            r_ring_end  <= RING_BASE_RST + RING_LAST_OFS;
            r_win_addr  <= WINDOW_ADDR_RST;
            r_win_end   <= WINDOW_ADDR_RST + WINDOW_LAST_OFS;
            r_wrap_en   <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_RING_BASE: begin
                    r_ring_base <= i_cfg_data;
                    r_ring_end  <= i_cfg_data + RING_LAST_OFS;
                end
                CFG_WINDOW_ADDR: begin
                    r_win_addr <= i_cfg_data;
                    r_win_end  <= i_cfg_data + WINDOW_LAST_OFS;
                end
                CFG_WRAP_EN: begin
                    r_wrap_en <= i_cfg_data[0];
                end
                default: begin
                end
            endcase
        end
    end

    smas_datapath #(
        .MEM_WORDS (MEM_WORDS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (in_accept),
        .i_req       (req),
        .o_stat      (dp_stat),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    assign o_out_valid  = (r_count != '0);
    assign pop          = o_out_valid && !i_out_stall;
    assign o_reply_byte = r_fifo[r_rd_ptr].reply;
    assign o_phase      = r_fifo[r_rd_ptr].phase;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (res_valid) begin
                r_wr_ptr <= r_wr_ptr + PTR_W'(1);
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + PTR_W'(1);
            end
            if (res_valid && !pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (pop && !res_valid) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_valid) begin
            r_fifo[r_wr_ptr] <= res;
        end
    end

`ifndef ASSERT_OFF
    a_no_queue_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (res_valid && !pop) |-> (r_count < CNT_W'(OUT_DEPTH)))
        else $error("result pushed into a full queue");

    a_active_phase_needs_select: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase != PH_IDLE) |-> r_selected)
        else $error("transaction phase active while deselected");

    a_fill_only_in_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fill != 2'd0) |-> (r_phase == PH_WR_DATA))
        else $error("partial write word outside the write data phase");
`endif

endmodule

// ----- rtl/core/smas_datapath.sv -----
// Memory stage of the SPI memory access slave: word RAM, read-modify-write and byte buffer.
`timescale 1ns / 1ps

module smas_datapath import smas_pkg::*; #(
    parameter int MEM_WORDS = 4096
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_req_valid,
    input  t_dp_req  i_req,
    output t_dp_stat o_stat,
    output logic     o_res_valid,
    output t_result  o_res
);

    localparam int IDX_W = $clog2(MEM_WORDS);

    typedef logic [IDX_W-1:0] t_idx;

    function automatic t_idx word_idx(input t_addr a);
        word_idx = a[IDX_W+1:2];
    endfunction

    logic [31:0] r_mem [MEM_WORDS];
    logic [31:0] r_mem_q;
    logic        r_fwd_hit;
    logic [31:0] r_fwd_data;

    logic        r_s2_valid;
    t_dp_req     r_s2;
    logic        r_flush_b;
    logic [31:0] r_word_a;
    logic [31:0] r_wbuf;
    logic [31:0] n_wbuf;

    logic        r_clr_active;
    t_idx        r_clr_idx;

    logic        flush_a;
    logic        s2_done;
    t_idx        rd_idx;
    logic        wr_en;
    t_idx        wr_idx;
    logic [31:0] wr_data;
    logic [31:0] mem_word;
    logic [1:0]  c0;
    logic [1:0]  tail_ofs;
    logic [31:0] keep_mask;
    logic [31:0] wr_word;
    logic [31:0] rd_start_word;
    logic [31:0] rd_word;
    logic [31:0] flush_word;
    logic [7:0]  reply;

    assign flush_a  = r_s2_valid && (r_s2.op == OP_FLUSH) && !r_flush_b;
    assign s2_done  = r_s2_valid && !flush_a;
    assign c0       = r_s2.cursor[1:0];
    assign tail_ofs = 2'd3 - r_s2.fill;
    assign mem_word = r_fwd_hit ? r_fwd_data : r_mem_q;

    // The second word of a flush is read while the stage holds the first one.
    assign rd_idx = flush_a ? word_idx(r_s2.cursor + t_addr'(tail_ofs))
                            : word_idx(i_req.cursor);

    always_comb begin
        case (r_s2.fill)
            2'd1:    keep_mask = 32'h0000_00FF;
            2'd2:    keep_mask = 32'h0000_FFFF;
            2'd3:    keep_mask = 32'h00FF_FFFF;
            default: keep_mask = 32'h0000_0000;
        endcase
    end

    always_comb begin
        wr_word = (r_s2.op == OP_WR_START) ? (mem_word & keep_mask) : r_wbuf;
        wr_word[8*r_s2.fill +: 8] = r_s2.data;
    end

    always_comb begin
        case (c0)
            2'd1:    rd_start_word = {8'h00, mem_word[31:8]};
            2'd2:    rd_start_word = {16'h0000, mem_word[31:16]};
            2'd3:    rd_start_word = {24'h00_0000, mem_word[31:24]};
            default: rd_start_word = 32'h0000_0000;
        endcase
    end

    assign rd_word = (c0 == 2'd0) ? mem_word : r_wbuf;

    // Lanes below the fill come from the buffer; the rest are memory bytes from
    // the cursor onward, which may run from the first word into the second.
    always_comb begin
        logic [2:0]  k;
        logic [2:0]  pos;
        logic [31:0] src;
        flush_word = '0;
        for (int l = 0; l < 4; l++) begin
            k   = 3'(l) - {1'b0, r_s2.fill};
            pos = {1'b0, c0} + k;
            src = pos[2] ? mem_word : r_word_a;
            if (3'(l) < {1'b0, r_s2.fill}) begin
                flush_word[8*l +: 8] = r_wbuf[8*l +: 8];
            end else begin
                flush_word[8*l +: 8] = src[8*pos[1:0] +: 8];
            end
        end
    end

    always_comb begin
        wr_en   = 1'b0;
        wr_idx  = r_clr_idx;
        wr_data = '0;
        if (r_clr_active) begin
            wr_en = 1'b1;
        end else if (s2_done) begin
            case (r_s2.op)
                OP_WR_START, OP_WR_BYTE: begin
                    if (r_s2.fill == 2'd3) begin
                        wr_en   = 1'b1;
                        wr_idx  = word_idx(r_s2.cursor - 22'd3);
                        wr_data = wr_word;
                    end
                end
                OP_FLUSH: begin
                    wr_en   = 1'b1;
                    wr_idx  = word_idx(r_s2.cursor - t_addr'(r_s2.fill));
                    wr_data = flush_word;
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        n_wbuf = r_wbuf;
        reply  = 8'h00;
        case (r_s2.op)
            OP_RD_START: begin
                n_wbuf = rd_start_word;
            end
            OP_RD_BYTE: begin
                reply  = rd_word[7:0];
                n_wbuf = {8'h00, rd_word[31:8]};
            end
            OP_WR_START, OP_WR_BYTE: begin
                n_wbuf = (r_s2.fill == 2'd3) ? 32'h0000_0000 : wr_word;
            end
            OP_FLUSH: begin
                n_wbuf = 32'h0000_0000;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_idx] <= wr_data;
        end
        r_mem_q <= r_mem[rd_idx];
    end

    // A read issued in the cycle of a write to the same word sees the new data.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd_hit <= 1'b0;
        end else begin
            r_fwd_hit <= wr_en && (wr_idx == rd_idx);
        end
        r_fwd_data <= wr_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_active <= 1'b1;
            r_clr_idx    <= '0;
        end else if (r_clr_active) begin
            r_clr_idx <= r_clr_idx + t_idx'(1);
            if (r_clr_idx == t_idx'(MEM_WORDS - 1)) begin
                r_clr_active <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
            r_flush_b  <= 1'b0;
        end else begin
            if (i_req_valid) begin
                r_s2_valid <= 1'b1;
            end else if (s2_done) begin
                r_s2_valid <= 1'b0;
            end
            if (flush_a) begin
                r_flush_b <= 1'b1;
            end else if (s2_done) begin
                r_flush_b <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req_valid) begin
            r_s2 <= i_req;
        end
        if (flush_a) begin
            r_word_a <= mem_word;
        end
        if (s2_done) begin
            r_wbuf <= n_wbuf;
        end
    end

    assign o_stat.busy      = r_clr_active || flush_a;
    assign o_stat.in_flight = r_s2_valid;
    assign o_res_valid      = s2_done;
    assign o_res.reply      = reply;
    assign o_res.phase      = r_s2.phase;

`ifndef ASSERT_OFF
    a_no_item_while_clearing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clr_active |-> !r_s2_valid)
        else $error("item in memory stage during clearing pass");

    a_no_req_during_second_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        flush_a |-> !i_req_valid)
        else $error("new item while flush reads its second word");

    a_flush_b_owner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_flush_b |-> (r_s2_valid && (r_s2.op == OP_FLUSH)))
        else $error("second flush cycle without a flush in the stage");
`endif

endmodule

// ----- bench/tb_spi_memory_access_slave.sv -----
// Self-checking testbench for the SPI memory access slave: random and directed host traffic against a local model.
`timescale 1ns / 1ps

module tb_spi_memory_access_slave;
    import smas_pkg::*;

    localparam int MEM_WORDS   = 4096;
    localparam int CYCLE_LIMIT = 400000;
    localparam int SEG_ITEMS   = 260;
    localparam int HOLD_CYCLES = 250;

    typedef struct packed {
        logic       cmd;
        logic [7:0] data;
        logic       sel;
    } t_host_item;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_cmd = CMD_SELECT;
    logic [7:0]  in_data = 8'h00;
    logic        in_sel = 1'b0;
    logic        out_stall = 1'b0;
    logic        cfg_we = 1'b0;
    t_cfg_idx    cfg_idx = CFG_RING_BASE;
    t_addr       cfg_data = '0;
    logic        in_stall;
    logic        out_valid;
    logic [7:0]  reply_byte;
    logic [2:0]  phase;

    t_host_item  pending_items[$];
    t_result     replies_due[$];

    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    int          items_accepted = 0;
    int          replies_checked = 0;
    int          mismatches = 0;
    int          built_items = 0;
    int          settings_used = 0;
    int          cycles = 0;
    bit          hold_armed = 1'b0;
    bit          hold_done = 1'b0;
    int          hold_at = 0;
    int          hold_left = 0;

    // Local copy of the slave state and its registers.
    logic [31:0] mem_model [0:MEM_WORDS-1];
    t_phase      m_phase;
    t_addr       cursor_m;
    logic [1:0]  m_addr_cnt;
    logic [31:0] m_wbuf;
    int unsigned m_fill;
    t_addr       m_wr_start;
    logic        m_sel;
    t_addr       ring_base_m;
    t_addr       window_m;
    logic        wrap_en_m;

    spi_memory_access_slave #(
        .MEM_WORDS(MEM_WORDS)
    ) u_dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .o_in_stall     (in_stall),
        .i_cmd          (in_cmd),
        .i_data_byte    (in_data),
        .i_select_level (in_sel),
        .o_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .o_reply_byte   (reply_byte),
        .o_phase        (phase),
        .i_cfg_we       (cfg_we),
        .i_cfg_idx      (cfg_idx),
        .i_cfg_data     (cfg_data)
    );

    initial begin
        forever #2 clk = ~clk;
    end

    // ---------------------------------------------------------------- model

    function automatic int unsigned word_at(t_addr a);
        return int'(a[21:2]) % MEM_WORDS;
    endfunction

    function automatic logic [7:0] mem_byte(t_addr a);
        return 8'(mem_model[word_at(a)] >> (8 * a[1:0]));
    endfunction

    function automatic void apply_select(logic lvl);
        if (lvl == m_sel) return;
        m_sel = lvl;
        // A partly filled word is completed from memory before it is stored.
        if (m_fill != 0) begin
            while (m_fill < 32) begin
                m_wbuf = m_wbuf | (32'(mem_byte(cursor_m)) << m_fill);
                m_fill += 8;
                cursor_m = cursor_m + 22'd1;
            end
            mem_model[word_at(cursor_m - 22'd4)] = m_wbuf;
            m_wbuf = '0;
            m_fill = 0;
        end
        m_phase = PH_IDLE;
        cursor_m = '0;
        m_addr_cnt = '0;
    endfunction

    function automatic void store_data_byte(logic [7:0] d);
        t_addr ring_end;
        t_addr win_end;
        ring_end = ring_base_m + RING_LAST_OFS;
        win_end = window_m + WINDOW_LAST_OFS;
        m_wbuf = m_wbuf | (32'(d) << m_fill);
        m_fill += 8;
        if (m_fill == 32) begin
            mem_model[word_at(cursor_m - 22'd3)] = m_wbuf;
            m_wbuf = '0;
            m_fill = 0;
        end
        if (cursor_m == ring_end && m_wr_start >= ring_base_m) begin
            cursor_m = ring_base_m;
        end else if (wrap_en_m && cursor_m == win_end) begin
            cursor_m = window_m;
        end else begin
            cursor_m = cursor_m + 22'd1;
        end
    endfunction

    function automatic logic [7:0] shift_in_byte(logic [7:0] d);
        logic [7:0] r;
        r = 8'h00;
        if (!m_sel) return r;
        case (m_phase)
            PH_IDLE: begin
                case (d[7:6])
                    HOST_READ: begin
                        m_phase = PH_RD_ADDR;
                        cursor_m = t_addr'(d[5:0]);
                    end
                    HOST_UNIMPL: m_phase = PH_UNIMPL;
                    HOST_WRITE: begin
                        m_phase = PH_WR_ADDR;
                        cursor_m = t_addr'(d[5:0]);
                    end
                    default: m_phase = PH_INVALID;
                endcase
            end
            PH_RD_ADDR: begin
                if (m_addr_cnt < ADDR_TAIL_BYTES) begin
                    m_addr_cnt++;
                    cursor_m = {cursor_m[13:0], d};
                end else begin
                    // This is the dummy byte; a misaligned start preloads its word.
                    m_phase = PH_RD_DATA;
                    if (cursor_m[1:0] != 2'd0)
                        m_wbuf = mem_model[word_at(cursor_m)] >> (8 * cursor_m[1:0]);
                    else
                        m_wbuf = '0;
                end
            end
            PH_WR_ADDR: begin
                if (m_addr_cnt < ADDR_TAIL_BYTES) begin
                    m_addr_cnt++;
                    cursor_m = {cursor_m[13:0], d};
                end else begin
                    m_phase = PH_WR_DATA;
                    if (cursor_m[1:0] != 2'd0) begin
                        m_fill = 8 * cursor_m[1:0];
                        m_wbuf = mem_model[word_at(cursor_m)] & ((32'd1 << m_fill) - 32'd1);
                    end else begin
                        m_wbuf = '0;
                        m_fill = 0;
                    end
                    m_wr_start = cursor_m;
                    store_data_byte(d);
                end
            end
            PH_RD_DATA: begin
                if (cursor_m[1:0] == 2'd0)
                    m_wbuf = mem_model[word_at(cursor_m)];
                r = m_wbuf[7:0];
                m_wbuf = m_wbuf >> 8;
                cursor_m = cursor_m + 22'd1;
            end
            PH_WR_DATA: store_data_byte(d);
            default: ;
        endcase
        return r;
    endfunction

    function automatic t_result next_reply(t_host_item it);
        t_result res;
        res.reply = 8'h00;
        if (it.cmd == CMD_SELECT)
            apply_select(it.sel);
        else
            res.reply = shift_in_byte(it.data);
        res.phase = m_phase;
        return res;
    endfunction

    // ------------------------------------------------------------- stimulus

    function automatic void push_item(logic cmd, logic [7:0] d, logic lvl);
        t_host_item it;
        it.cmd = cmd;
        it.data = d;
        it.sel = lvl;
        pending_items.push_back(it);
        built_items++;
    endfunction

    function automatic void push_select(logic lvl);
        push_item(CMD_SELECT, 8'($urandom), lvl);
    endfunction

    function automatic void push_byte(logic [7:0] d);
        push_item(CMD_TRANSFER, d, 1'($urandom));
    endfunction

    function automatic t_addr pick_addr();
        case ($urandom_range(5))
            0: return ring_base_m + RING_LAST_OFS - t_addr'($urandom_range(9));
            1: return window_m + t_addr'($urandom_range(7)) - 22'd4;
            2, 3: return {8'($urandom), 8'h12, 6'($urandom)};
            4: return t_addr'($urandom);
            default: return 22'h3FFFFF - t_addr'($urandom_range(5));
        endcase
    endfunction

    function automatic int pick_len();
        if ($urandom_range(9) == 0) return $urandom_range(40);
        return $urandom_range(12);
    endfunction

    function automatic void queue_transaction();
        t_addr a;
        int len;
        int kind;
        t_host_item noise;
        a = pick_addr();
        len = pick_len();
        kind = $urandom_range(99);
        if (kind < 72) begin
            // Well-formed read or write with random content.
            push_select(1'b1);
            if (kind < 40) begin
                push_byte({HOST_WRITE, a[21:16]});
                push_byte(a[15:8]);
                push_byte(a[7:0]);
                repeat (len) push_byte(8'($urandom));
            end else begin
                push_byte({HOST_READ, a[21:16]});
                push_byte(a[15:8]);
                push_byte(a[7:0]);
                if (len != 0) repeat (len + 1) push_byte(8'($urandom));
            end
            if ($urandom_range(9) == 0) push_select(1'b1);
            push_select(1'b0);
        end else if (kind < 82) begin
            push_select(1'b1);
            push_byte({($urandom_range(1) ? HOST_INVALID : HOST_UNIMPL), 6'($urandom)});
            repeat ($urandom_range(4)) push_byte(8'($urandom));
            push_select(1'b0);
        end else if (kind < 92) begin
            // Transaction cut short before the address is complete.
            push_select(1'b1);
            push_byte({($urandom_range(1) ? HOST_WRITE : HOST_READ), a[21:16]});
            if ($urandom_range(1)) push_byte(a[15:8]);
            push_select(1'b0);
        end else begin
            // Ignored by the block, so these are left out of the item count.
            noise.cmd = 1'($urandom);
            noise.data = 8'($urandom);
            noise.sel = 1'b0;
            pending_items.push_back(noise);
        end
    endfunction

    function automatic void queue_directed();
        push_byte(8'hFF);               // transfer while deselected
        push_select(1'b0);              // unchanged level
        push_select(1'b1);
        push_select(1'b1);
        push_byte({HOST_WRITE, 6'h3F});
        push_byte(8'hFF);
        push_byte(8'hFE);
        push_byte(8'h00);               // also the first data byte
        push_byte(8'hFF);
        push_byte(8'hA5);               // cursor rolls over the top of the space
        push_select(1'b0);              // stores the partial word
        push_select(1'b1);
        push_byte({HOST_READ, 6'h3F});
        push_byte(8'hFF);
        push_byte(8'hFE);
        push_byte(8'h55);
        repeat (4) push_byte(8'h00);
        push_select(1'b0);
        push_select(1'b1);
        push_byte({HOST_UNIMPL, 6'h00});
        push_byte(8'h12);
        push_select(1'b0);
        push_select(1'b1);
        push_byte({HOST_INVALID, 6'h3F});
        push_byte(8'h00);
        push_select(1'b0);
    endfunction

    task automatic write_cfg(t_cfg_idx idx, t_addr val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_RING_BASE:   ring_base_m = val;
            CFG_WINDOW_ADDR: window_m = val;
            default:         wrap_en_m = val[0];
        endcase
    endtask

    task automatic wait_drained();
        while (pending_items.size() != 0 || in_valid || replies_due.size() != 0)
            @(posedge clk);
        // Covers the result path and a flush that reads a second word.
        repeat (8) @(posedge clk);
    endtask

    initial begin : stimulus
        int seg;
        foreach (mem_model[k]) mem_model[k] = '0;
        m_phase = PH_IDLE;
        cursor_m = '0;
        m_addr_cnt = '0;
        m_wbuf = '0;
        m_fill = 0;
        m_wr_start = '0;
        m_sel = 1'b0;
        ring_base_m = RING_BASE_RST;
        window_m = WINDOW_ADDR_RST;
        wrap_en_m = 1'b0;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        for (seg = 0; seg < 4; seg++) begin
            case (seg)
                0: begin
                    send_idle_pct = 24; recv_idle_pct = 83;
                    write_cfg(CFG_RING_BASE, RING_BASE_RST);
                    write_cfg(CFG_WINDOW_ADDR, WINDOW_ADDR_RST);
                    write_cfg(CFG_WRAP_EN, 22'd0);
                end
                1: begin
                    send_idle_pct = 24; recv_idle_pct = 83;
                    write_cfg(CFG_RING_BASE, 22'h000000);
                    write_cfg(CFG_WINDOW_ADDR, 22'h3FFFFF);
                    write_cfg(CFG_WRAP_EN, 22'd1);
                end
                2: begin
                    send_idle_pct = 83; recv_idle_pct = 24;
                    write_cfg(CFG_RING_BASE, 22'h3FFFFF);
                    write_cfg(CFG_WINDOW_ADDR, 22'h000000);
                    write_cfg(CFG_WRAP_EN, 22'd0);
                end
                default: begin
                    send_idle_pct = 0; recv_idle_pct = 0;
                    write_cfg(CFG_RING_BASE, t_addr'($urandom));
                    write_cfg(CFG_WINDOW_ADDR, t_addr'($urandom));
                    write_cfg(CFG_WRAP_EN, 22'd1);
                    hold_at = replies_checked + 40;
                    hold_armed = 1'b1;
                end
            endcase
            settings_used++;
            if (seg == 0) queue_directed();
            built_items = 0;
            while (built_items < SEG_ITEMS) queue_transaction();
            wait_drained();
        end

        $display("Summary: %0d host items over %0d register settings, %0d replies checked,",
                 items_accepted, settings_used, replies_checked);
        $display("         %0d mismatches, long output hold %0s.",
                 mismatches, hold_done ? "done" : "not reached");
        if (mismatches == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    // --------------------------------------------------------------- driver

    always @(posedge clk) begin : drive_proc
        t_host_item nxt;
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && !in_stall) begin
                nxt.cmd = in_cmd;
                nxt.data = in_data;
                nxt.sel = in_sel;
                replies_due.push_back(next_reply(nxt));
                items_accepted++;
            end
            if (!in_valid || !in_stall) begin
                if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    nxt = pending_items.pop_front();
                    in_valid <= 1'b1;
                    in_cmd <= nxt.cmd;
                    in_data <= nxt.data;
                    in_sel <= nxt.sel;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // -------------------------------------------------------------- monitor

    always @(posedge clk) begin : receive_proc
        t_result want;
        logic stall_next;
        if (!rst_n) begin
            out_stall <= 1'b0;
        end else begin
            if (out_valid && !out_stall) begin
                if (replies_due.size() == 0) begin
                    $error("unexpected reply: reply_byte %0h phase %0d", reply_byte, phase);
                    mismatches++;
                end else begin
                    want = replies_due.pop_front();
                    if (reply_byte !== want.reply) begin
                        $error("reply_byte: expected %0h, got %0h", want.reply, reply_byte);
                        mismatches++;
                    end
                    if (phase !== want.phase) begin
                        $error("phase: expected %0d, got %0d", want.phase, phase);
                        mismatches++;
                    end
                end
                replies_checked++;
            end
            // One long hold lets the result queue fill so the input side backs up.
            if (hold_left != 0) begin
                hold_left--;
                stall_next = 1'b1;
            end else if (hold_armed && !hold_done && replies_checked >= hold_at) begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
                stall_next = 1'b1;
            end else begin
                stall_next = ($urandom_range(99) < recv_idle_pct);
            end
            out_stall <= stall_next;
        end
    end

    always @(posedge clk) begin : watchdog
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d replies still due.",
                     cycles, replies_due.size());
            $display("FAIL");
            $finish;
        end
    end

endmodule
